// File: hw/rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    localparam int MAX_JOBS = 16;
    localparam int SLOT_W   = $clog2(MAX_JOBS);

    typedef enum logic
    {
        MODE_ARRIVAL = 1'b0,
        MODE_TICK    = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_IDLE = 2'd2
    } status_t;

    typedef struct packed
    {
        mode_t       mode;
        logic [7:0]  job_id;
        logic [15:0] burst_length;
        logic [7:0]  job_priority;
    } req_item_t;

    typedef struct packed
    {
        status_t     status;
        logic        ran;
        logic [7:0]  run_job_id;
        logic        preempted;
        logic        done_res;
        logic [7:0]  done_job_id;
        logic [31:0] turnaround;
        logic [31:0] wait_time;
        logic [31:0] now;
    } rsp_item_t;

    // One job's context, as held by the current-job register or a ready slot.
    typedef struct packed
    {
        logic [7:0]  id;
        logic [15:0] remaining;
        logic [7:0]  prio;
        logic [31:0] arrival;
        logic [15:0] burst;
    } job_t;

endpackage

// File: hw/rtl/pps_if.sv
// Valid/ready stream interfaces for the scheduler's request and result channels.
interface pps_req_if;
    logic               valid;
    logic               ready;
    pps_pkg::req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pps_rsp_if;
    logic               valid;
    logic               ready;
    pps_pkg::rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: current job, ready store and result register.
//
//   channel | dir | payload                          | accepted when
//   --------+-----+----------------------------------+---------------------------
//   req     | in  | mode, job_id, burst_length, prio | req.valid && req.ready
//   rsp     | out | status, ran, ids, times, now     | rsp.valid && rsp.ready
//
// The scheduler state is updated and the result register is loaded at the edge
// that accepts an item. The path is bounded by the min-priority tree over the
// ready slots and the time subtractions.
// req.ready is high whenever the result register is empty or being drained,
// so items stream at one per cycle while rsp keeps up.
// Reset clears the time counter, the current job and all slot valid bits.
module preemptive_priority_scheduler
(
    input  logic           clk,
    input  logic           rst_n,
    pps_req_if.sink        req,
    pps_rsp_if.source      rsp
);

    localparam int NLEAF = 1 << pps_pkg::SLOT_W;
    localparam int NODES = 2 * NLEAF - 1;

    // Scheduler state
    logic [31:0]                  time_reg, time_next;
    logic                         cur_valid_reg, cur_valid_next;
    pps_pkg::job_t                cur_reg, cur_next;
    logic [pps_pkg::MAX_JOBS-1:0] slot_valid_reg, slot_valid_next;
    pps_pkg::job_t                slot_mem [pps_pkg::MAX_JOBS];

    // Result register
    logic                         rsp_valid_reg, rsp_valid_next;
    pps_pkg::rsp_item_t           rsp_data_reg, rsp_data_next;

    // Slot write port
    logic                         slot_we;
    logic [pps_pkg::SLOT_W-1:0]   slot_waddr;
    pps_pkg::job_t                slot_wdata;

    // Lowest free slot
    logic                         free_found;
    logic [pps_pkg::SLOT_W-1:0]   free_idx;

    // Min-priority tree, heap order: node n has children 2n+1 and 2n+2
    logic                         node_valid [NODES];
    logic [7:0]                   node_prio  [NODES];
    logic [pps_pkg::SLOT_W-1:0]   node_idx   [NODES];
    logic                         best_found;
    logic [pps_pkg::SLOT_W-1:0]   best_idx;
    pps_pkg::job_t                best_job;

    logic                         accept;
    logic [31:0]                  turn;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = pps_pkg::MAX_JOBS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = pps_pkg::SLOT_W'(i);
            end
        end
    end

    // Ties go to the left child, which always holds the lower slot numbers.
    always_comb
    begin
        int l;
        int r;
        for (int i = 0; i < NLEAF; i++)
        begin
            node_valid[NLEAF-1+i] = 1'b0;
            node_prio[NLEAF-1+i]  = '0;
            node_idx[NLEAF-1+i]   = pps_pkg::SLOT_W'(i);
        end
        for (int i = 0; i < pps_pkg::MAX_JOBS; i++)
        begin
            node_valid[NLEAF-1+i] = slot_valid_reg[i];
            node_prio[NLEAF-1+i]  = slot_mem[i].prio;
        end
        for (int n = NLEAF - 2; n >= 0; n--)
        begin
            l = 2 * n + 1;
            r = 2 * n + 2;
            if (node_valid[l] && (!node_valid[r] || node_prio[l] <= node_prio[r]))
            begin
                node_valid[n] = 1'b1;
                node_prio[n]  = node_prio[l];
                node_idx[n]   = node_idx[l];
            end
            else
            begin
                node_valid[n] = node_valid[r];
                node_prio[n]  = node_prio[r];
                node_idx[n]   = node_idx[r];
            end
        end
        best_found = node_valid[0];
        best_idx   = node_idx[0];
    end

    assign best_job = slot_mem[best_idx];

    // Time of completion is the advanced counter.
    assign turn = (time_reg + 32'd1) - cur_reg.arrival;

    always_comb
    begin
        time_next       = time_reg;
        cur_valid_next  = cur_valid_reg;
        cur_next        = cur_reg;
        slot_valid_next = slot_valid_reg;
        slot_we         = 1'b0;
        slot_waddr      = free_idx;
        slot_wdata      = cur_reg;
        rsp_data_next   = rsp_data_reg;

        if (accept)
        begin
            rsp_data_next = '0;
            unique case (req.data.mode)
                pps_pkg::MODE_ARRIVAL:
                begin
                    priority if (!cur_valid_reg)
                    begin
                        cur_valid_next = 1'b1;
                        cur_next       = '{id: req.data.job_id,
                                           remaining: req.data.burst_length,
                                           prio: req.data.job_priority,
                                           arrival: time_reg,
                                           burst: req.data.burst_length};
                    end
                    else if (!free_found)
                    begin
                        rsp_data_next.status = pps_pkg::STATUS_FULL;
                    end
                    else if (req.data.job_priority < cur_reg.prio)
                    begin
                        // Displaced job goes to the store with its progress.
                        slot_we                  = 1'b1;
                        slot_wdata               = cur_reg;
                        slot_valid_next[free_idx] = 1'b1;
                        cur_next       = '{id: req.data.job_id,
                                           remaining: req.data.burst_length,
                                           prio: req.data.job_priority,
                                           arrival: time_reg,
                                           burst: req.data.burst_length};
                        rsp_data_next.preempted = 1'b1;
                    end
                    else
                    begin
                        slot_we                  = 1'b1;
                        slot_wdata               = '{id: req.data.job_id,
                                                     remaining: req.data.burst_length,
                                                     prio: req.data.job_priority,
                                                     arrival: time_reg,
                                                     burst: req.data.burst_length};
                        slot_valid_next[free_idx] = 1'b1;
                    end
                    rsp_data_next.run_job_id = cur_next.id;
                end
                pps_pkg::MODE_TICK:
                begin
                    time_next = time_reg + 32'd1;
                    if (!cur_valid_reg)
                    begin
                        rsp_data_next.status = pps_pkg::STATUS_IDLE;
                    end
                    else
                    begin
                        rsp_data_next.ran        = 1'b1;
                        rsp_data_next.run_job_id = cur_reg.id;
                        // A zero burst finishes after one tick, like a burst of one.
                        if (cur_reg.remaining <= 16'd1)
                        begin
                            rsp_data_next.done_res    = 1'b1;
                            rsp_data_next.done_job_id = cur_reg.id;
                            rsp_data_next.turnaround  = turn;
                            rsp_data_next.wait_time   = turn - {16'd0, cur_reg.burst};
                            if (best_found)
                            begin
                                cur_next                  = best_job;
                                slot_valid_next[best_idx] = 1'b0;
                            end
                            else
                            begin
                                cur_valid_next     = 1'b0;
                                cur_next.remaining = '0;
                            end
                        end
                        else
                        begin
                            cur_next.remaining = cur_reg.remaining - 16'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            rsp_data_next.now = time_next;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            cur_valid_reg  <= 1'b0;
            cur_reg        <= '0;
            slot_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            time_reg       <= time_next;
            cur_valid_reg  <= cur_valid_next;
            cur_reg        <= cur_next;
            slot_valid_reg <= slot_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload storage, no reset.
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
    end

endmodule
